// ----- sv/balpd_pkg.sv -----
// balpd_pkg: shared types and constants of the balance drive controller
// word layouts, register indexes, reset values, integral bound and zone table
// no dependencies
package balpd_pkg;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] gyro_rate;
    logic signed [15:0] wheel_count;
  } in_word_t;

  typedef struct packed {
    logic signed [16:0] drive;
    logic               in_zone;
  } out_word_t;

  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd4;

  // register reset values
  localparam logic [19:0] ANGLE_GAIN_RST    = 20'd243200;
  localparam logic [15:0] RATE_GAIN_RST     = 16'd1280;
  localparam logic [15:0] SPEED_GAIN_RST    = 16'd21760;
  localparam logic [15:0] INTEGRAL_GAIN_RST = 16'd64;
  localparam logic [15:0] DRIVE_LIMIT_RST   = 16'd7200;

  // speed integral bound
  localparam logic signed [16:0] INTEG_HI = 17'sd10000;
  localparam logic signed [16:0] INTEG_LO = -17'sd10000;

  // reciprocals for the truncating divisions: ceil(2^22/10) and ceil(2^34/25)
  localparam logic signed [30:0] FILT_RECIP = 31'sd419431;
  localparam logic signed [30:0] UP_RECIP   = 31'sd687194768;

  // balance zones, strict bounds in centidegrees
  localparam logic signed [15:0] ZONE_A_LO = -16'sd10000;
  localparam logic signed [15:0] ZONE_A_HI = -16'sd7000;
  localparam logic signed [15:0] ZONE_B_LO = -16'sd2000;
  localparam logic signed [15:0] ZONE_B_HI = 16'sd1000;
  localparam logic signed [15:0] ZONE_C_LO = 16'sd7000;
  localparam logic signed [15:0] ZONE_C_HI = 16'sd10000;
  localparam logic signed [15:0] ZONE_D_LO = 16'sd17000;
  localparam logic signed [15:0] ZONE_D_HI = 16'sd18000;
  localparam logic signed [15:0] ZONE_E_LO = -16'sd18000;
  localparam logic signed [15:0] ZONE_E_HI = -16'sd16000;

  // mid angles set by the zones
  localparam logic signed [15:0] MID_A = -16'sd8500;
  localparam logic signed [15:0] MID_B = -16'sd400;
  localparam logic signed [15:0] MID_C = 16'sd8600;
  localparam logic signed [15:0] MID_D = -16'sd17300;

endpackage

// ----- sv/balance_pd_pi_drive.sv -----
// balance_pd_pi_drive: cascaded upright pd and speed pi drive controller
// sequencer around one shared multiplier, divisions by reciprocal multiply
// depends on balpd_pkg
//
// Usage: one input word per control tick carries roll angle, gyro rate and
// encoder delta; it is accepted on a rising edge with in_valid high and
// in_stall low. Each word yields exactly one output word (drive, in_zone) on
// out_valid/out_stall. Gains and the drive limit are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce; unknown indexes are ignored.
// in_stall is high from acceptance until the result is loaded into the output
// register, so no new word is taken before then. The sequence makes six passes
// through the shared multiplier (filter reciprocal, four gain products, upright
// reciprocal) with two accumulate steps, a magnitude load and the final sum.
// If the receiver stalls, the finished result waits in the working registers
// and the block stays in its final step until the output register frees up; a
// new word is then accepted while the result is still waiting to be taken.
// Reset (rst, synchronous) loads the default gains, clears mid angle, speed
// filter and integral, and empties the output register.
module balance_pd_pi_drive
  import balpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FMUL  = 4'd1;
  localparam logic [3:0] S_FEND  = 4'd2;
  localparam logic [3:0] S_MSG   = 4'd3;
  localparam logic [3:0] S_MIG   = 4'd4;
  localparam logic [3:0] S_SACC  = 4'd5;
  localparam logic [3:0] S_MAG   = 4'd6;
  localparam logic [3:0] S_MRG   = 4'd7;
  localparam logic [3:0] S_UACC  = 4'd8;
  localparam logic [3:0] S_ULOAD = 4'd9;
  localparam logic [3:0] S_UMUL  = 4'd10;
  localparam logic [3:0] S_SUM   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  // configuration and control state
  logic [19:0]        angle_gain;
  logic [15:0]        rate_gain;
  logic [15:0]        speed_gain;
  logic [15:0]        integral_gain;
  logic [15:0]        drive_limit;
  logic signed [15:0] mid_angle;
  logic signed [15:0] filtered_speed;
  logic signed [14:0] speed_integral;
  logic [3:0]         state;

  // working registers
  logic signed [15:0] roll;
  logic signed [15:0] gyro;
  logic signed [16:0] diff;
  logic [22:0]        rate100;
  logic [28:0]        mag;
  logic               mag_neg;
  logic signed [61:0] prod;
  logic signed [41:0] acc;
  logic signed [25:0] speed_term;
  logic signed [26:0] sum;
  logic               zone;
  logic signed [15:0] mid_sel;

  logic in_accept;
  logic out_free;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // filter numerator 3*enc + 7*filtered
  logic signed [19:0] enc_x;
  logic signed [19:0] filt_x;
  logic signed [19:0] num;
  logic [19:0]        num_mag;

  assign enc_x   = {{4{in_data.wheel_count[15]}}, in_data.wheel_count};
  assign filt_x  = {{4{filtered_speed[15]}}, filtered_speed};
  assign num     = (enc_x <<< 1) + enc_x + (filt_x <<< 3) - filt_x;
  assign num_mag = num[19] ? 20'(-num) : 20'(num);

  // filter result (magnitude * recip >> 22) and clamped integral
  logic signed [16:0] filt_q;
  logic signed [16:0] filt_new;
  logic signed [16:0] integ_sum;
  logic signed [14:0] integ_new;

  assign filt_q    = {1'b0, prod[37:22]};
  assign filt_new  = mag_neg ? -filt_q : filt_q;
  assign integ_sum = {{2{speed_integral[14]}}, speed_integral}
                   + {filt_new[15], filt_new[15:0]};

  always_comb begin
    if (integ_sum > INTEG_HI) begin
      integ_new = INTEG_HI[14:0];
    end else if (integ_sum < INTEG_LO) begin
      integ_new = INTEG_LO[14:0];
    end else begin
      integ_new = integ_sum[14:0];
    end
  end

  // shared multiplier
  logic signed [30:0] mul_a;
  logic signed [30:0] mul_b;
  logic signed [61:0] mul_p;

  always_comb begin
    case (state)
      S_FMUL: begin
        mul_a = {2'b0, mag};
        mul_b = FILT_RECIP;
      end
      S_MSG: begin
        mul_a = {15'b0, speed_gain};
        mul_b = {{15{filtered_speed[15]}}, filtered_speed};
      end
      S_MIG: begin
        mul_a = {15'b0, integral_gain};
        mul_b = {{16{speed_integral[14]}}, speed_integral};
      end
      S_MAG: begin
        mul_a = {11'b0, angle_gain};
        mul_b = {{14{diff[16]}}, diff};
      end
      S_MRG: begin
        mul_a = {8'b0, rate100};
        mul_b = {{15{gyro[15]}}, gyro};
      end
      S_UMUL: begin
        mul_a = {2'b0, mag};
        mul_b = UP_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // accumulator helpers
  logic signed [41:0] acc_sum;
  logic [41:0]        acc_mag;
  logic signed [25:0] speed_mag;
  logic signed [25:0] speed_val;

  assign acc_sum   = acc + $signed(prod[41:0]);
  assign acc_mag   = acc[41] ? 42'(-acc) : 42'(acc);
  assign speed_mag = {2'b0, acc_mag[31:8]};
  assign speed_val = acc[41] ? -speed_mag : speed_mag;

  // upright plus speed term, upright is (magnitude >> 10) * recip >> 34
  logic signed [26:0] up_q;
  logic signed [26:0] speed_x;
  logic signed [26:0] sum_val;

  assign up_q    = {2'b0, prod[58:34]};
  assign speed_x = {speed_term[25], speed_term};
  assign sum_val = mag_neg ? (speed_x - up_q) : (speed_x + up_q);

  // zone select
  logic               zone_hit;
  logic signed [15:0] zone_mid;

  always_comb begin
    zone_hit = 1'b1;
    zone_mid = mid_angle;
    if (roll > ZONE_A_LO && roll < ZONE_A_HI) begin
      zone_mid = MID_A;
    end else if (roll > ZONE_B_LO && roll < ZONE_B_HI) begin
      zone_mid = MID_B;
    end else if (roll > ZONE_C_LO && roll < ZONE_C_HI) begin
      zone_mid = MID_C;
    end else if ((roll > ZONE_D_LO && roll < ZONE_D_HI) ||
                 (roll > ZONE_E_LO && roll < ZONE_E_HI)) begin
      zone_mid = MID_D;
    end else begin
      zone_hit = 1'b0;
    end
  end

  // final clamp and negate
  logic signed [26:0] lim;
  logic signed [26:0] clamped;
  logic signed [26:0] drive_val;

  assign lim = {11'b0, drive_limit};

  always_comb begin
    if (sum > lim) begin
      clamped = lim;
    end else if (sum < -lim) begin
      clamped = -lim;
    end else begin
      clamped = sum;
    end
  end

  assign drive_val = -clamped;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_gain     <= ANGLE_GAIN_RST;
      rate_gain      <= RATE_GAIN_RST;
      speed_gain     <= SPEED_GAIN_RST;
      integral_gain  <= INTEGRAL_GAIN_RST;
      drive_limit    <= DRIVE_LIMIT_RST;
      mid_angle      <= '0;
      filtered_speed <= '0;
      speed_integral <= '0;
      state          <= S_IDLE;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ANGLE_GAIN:    angle_gain    <= cfg_data[19:0];
          REG_RATE_GAIN:     rate_gain     <= cfg_data[15:0];
          REG_SPEED_GAIN:    speed_gain    <= cfg_data[15:0];
          REG_INTEGRAL_GAIN: integral_gain <= cfg_data[15:0];
          REG_DRIVE_LIMIT:   drive_limit   <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_FMUL;
          end
        end
        S_FMUL:  state <= S_FEND;
        S_FEND: begin
          filtered_speed <= filt_new[15:0];
          speed_integral <= integ_new;
          state          <= S_MSG;
        end
        S_MSG:   state <= S_MIG;
        S_MIG:   state <= S_SACC;
        S_SACC:  state <= S_MAG;
        S_MAG:   state <= S_MRG;
        S_MRG:   state <= S_UACC;
        S_UACC:  state <= S_ULOAD;
        S_ULOAD: state <= S_UMUL;
        S_UMUL:  state <= S_SUM;
        S_SUM:   state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            if (zone) begin
              mid_angle <= mid_sel;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          roll    <= in_data.roll_angle;
          gyro    <= in_data.gyro_rate;
          diff    <= {in_data.roll_angle[15], in_data.roll_angle}
                   - {mid_angle[15], mid_angle};
          rate100 <= {1'b0, rate_gain, 6'b0} + {2'b0, rate_gain, 5'b0}
                   + {5'b0, rate_gain, 2'b0};
          mag     <= {10'b0, num_mag[18:0]};
          mag_neg <= num[19];
        end
      end
      S_FMUL, S_MSG, S_UMUL: prod <= mul_p;
      S_MIG: begin
        acc  <= $signed(prod[41:0]);
        prod <= mul_p;
      end
      S_SACC: acc <= acc_sum;
      S_MAG: begin
        speed_term <= speed_val;
        prod       <= mul_p;
      end
      S_MRG: begin
        acc  <= $signed(prod[41:0]);
        prod <= mul_p;
      end
      S_UACC: acc <= acc_sum;
      S_ULOAD: begin
        // trunc toward zero: magnitude / 1024 here, then / 25 by reciprocal
        mag     <= acc_mag[38:10];
        mag_neg <= acc[41];
      end
      S_SUM: begin
        sum     <= zone_hit ? sum_val : '0;
        zone    <= zone_hit;
        mid_sel <= zone_mid;
      end
      S_OUT: begin
        if (out_free) begin
          out_data.drive   <= drive_val[16:0];
          out_data.in_zone <= zone;
        end
      end
      default: ;
    endcase
  end

  // integral never leaves its bound
  a_integ_bound: assert property (@(posedge clk) disable iff (rst)
    (speed_integral <= INTEG_HI && speed_integral >= INTEG_LO))
    else $error("speed integral out of bound");

  // mid angle is always zero or a zone value
  a_mid_legal: assert property (@(posedge clk) disable iff (rst)
    (mid_angle == 16'sd0 || mid_angle == MID_A || mid_angle == MID_B ||
     mid_angle == MID_C || mid_angle == MID_D))
    else $error("illegal mid angle");

  // a stalled output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    ((out_valid && out_stall) |=> (out_valid && $stable(out_data))))
    else $error("stalled output word changed");

  // out of zone words carry zero drive
  a_zone_zero: assert property (@(posedge clk) disable iff (rst)
    ((out_valid && !out_data.in_zone) |-> (out_data.drive == 17'sd0)))
    else $error("nonzero drive outside zones");

  // the input side is held off while a result is pending in the last step
  a_hold_in: assert property (@(posedge clk) disable iff (rst)
    ((state == S_OUT && !out_free) |=> (state == S_OUT || in_stall)))
    else $error("left final step without a free output register");

endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking bench for balance_pd_pi_drive, with a predicting scoreboard class
// directed zone-edge words, then random traffic over several gain settings
// depends on balpd_pkg and balance_pd_pi_drive
`timescale 1ns / 1ps

module tb_top
  import balpd_pkg::*;
;

  localparam int RESULT_LATENCY = 12;
  localparam int RAND_PER_PHASE = 142;
  localparam int NUM_PHASES     = 8;
  localparam int HOLD_START     = 8000;
  localparam int HOLD_CYCLES    = 1500;

  class drive_scoreboard;
    longint angle_gain, rate_gain, speed_gain, integral_gain, drive_limit;
    longint mid_angle, filtered_speed, speed_integral;
    out_word_t pending_drives[$];
    int errors;

    function new();
      angle_gain     = ANGLE_GAIN_RST;
      rate_gain      = RATE_GAIN_RST;
      speed_gain     = SPEED_GAIN_RST;
      integral_gain  = INTEGRAL_GAIN_RST;
      drive_limit    = DRIVE_LIMIT_RST;
      mid_angle      = 0;
      filtered_speed = 0;
      speed_integral = 0;
      errors         = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_ANGLE_GAIN:    angle_gain    = val;
        REG_RATE_GAIN:     rate_gain     = val[15:0];
        REG_SPEED_GAIN:    speed_gain    = val[15:0];
        REG_INTEGRAL_GAIN: integral_gain = val[15:0];
        REG_DRIVE_LIMIT:   drive_limit   = val[15:0];
        default: ;
      endcase
    endfunction

    // works out the drive for one accepted input word
    function void note_word(in_word_t w);
      longint roll, gyro, enc, upright, speed, sum;
      bit zone;
      out_word_t res;
      roll = w.roll_angle;
      gyro = w.gyro_rate;
      enc  = w.wheel_count;
      zone = 1'b1;
      // upright term uses the mid angle of the previous tick
      upright = (angle_gain * (roll - mid_angle) + 100 * rate_gain * gyro) / 25600;
      filtered_speed = (3 * enc + 7 * filtered_speed) / 10;
      speed_integral = speed_integral + filtered_speed;
      if (speed_integral > INTEG_HI) speed_integral = INTEG_HI;
      if (speed_integral < INTEG_LO) speed_integral = INTEG_LO;
      speed = (speed_gain * filtered_speed + integral_gain * speed_integral) / 256;
      if (roll > ZONE_A_LO && roll < ZONE_A_HI) begin
        mid_angle = MID_A;
      end else if (roll > ZONE_B_LO && roll < ZONE_B_HI) begin
        mid_angle = MID_B;
      end else if (roll > ZONE_C_LO && roll < ZONE_C_HI) begin
        mid_angle = MID_C;
      end else if ((roll > ZONE_D_LO && roll < ZONE_D_HI) ||
                   (roll > ZONE_E_LO && roll < ZONE_E_HI)) begin
        mid_angle = MID_D;
      end else begin
        zone = 1'b0;
      end
      sum = zone ? upright + speed : 0;
      if (sum > drive_limit) sum = drive_limit;
      if (sum < -drive_limit) sum = -drive_limit;
      res.drive   = 17'(-sum);
      res.in_zone = zone;
      pending_drives.push_back(res);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (pending_drives.size() == 0) begin
        $error("result word with none pending: drive %0d in_zone %0b", got.drive, got.in_zone);
        errors++;
        return;
      end
      want = pending_drives.pop_front();
      if (got.drive !== want.drive) begin
        $error("drive: expected %0d, actual %0d", want.drive, got.drive);
        errors++;
      end
      if (got.in_zone !== want.in_zone) begin
        $error("in_zone: expected %0b, actual %0b", want.in_zone, got.in_zone);
        errors++;
      end
    endfunction

    function int pending();
      return pending_drives.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  drive_scoreboard sb;
  int burst_left = 0;
  int wheel_bias = 0;

  balance_pd_pi_drive uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_word(out_data);
      if (in_valid && !in_stall) sb.note_word(in_data);
    end
  end

  // receiver: changing stall pattern plus one long hold-off to back up the block
  initial begin : receiver
    int cycle_cnt = 0;
    int mode = 0;
    int mode_left = 0;
    int run_left = 0;
    logic run_val = 1'b0;
    forever begin
      @(negedge clk);
      cycle_cnt++;
      if (cycle_cnt >= HOLD_START && cycle_cnt < HOLD_START + HOLD_CYCLES) begin
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          default: begin
            if (run_left == 0) begin
              run_val = ~run_val;
              run_left = run_val ? $urandom_range(1, 80) : $urandom_range(1, 40);
            end
            run_left--;
            out_stall <= run_val;
          end
        endcase
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic in_word_t mk_word(int roll, int gyro, int wheel);
    in_word_t w;
    w.roll_angle  = 16'(roll);
    w.gyro_rate   = 16'(gyro);
    w.wheel_count = 16'(wheel);
    return w;
  endfunction

  function automatic in_word_t rand_word();
    int zlo[5] = '{ZONE_A_LO, ZONE_B_LO, ZONE_C_LO, ZONE_D_LO, ZONE_E_LO};
    int zhi[5] = '{ZONE_A_HI, ZONE_B_HI, ZONE_C_HI, ZONE_D_HI, ZONE_E_HI};
    int k, roll, gyro, wheel;
    k = $urandom_range(0, 4);
    case ($urandom_range(0, 9))
      0: roll = $urandom_range(0, 65535);
      1: roll = ($urandom_range(0, 1) ? zlo[k] : zhi[k]) + $urandom_range(0, 4) - 2;
      9: roll = $urandom_range(0, 36000) - 18000;
      default: roll = zlo[k] + 1 + $urandom_range(0, zhi[k] - zlo[k] - 2);
    endcase
    case ($urandom_range(0, 3))
      0: gyro = $urandom_range(0, 65535);
      1: gyro = $urandom_range(0, 1) ? 32767 : -32768;
      default: gyro = $urandom_range(0, 4000) - 2000;
    endcase
    // wheel counts drift around a bias so the filter and integral build up
    if ($urandom_range(0, 40) == 0) begin
      wheel_bias = $urandom_range(0, 3) == 0 ? int'(16'sh0 + 16'($urandom_range(0, 65535)))
                                             : $urandom_range(0, 4000) - 2000;
    end
    if ($urandom_range(0, 7) == 0) wheel = $urandom_range(0, 65535);
    else wheel = wheel_bias + $urandom_range(0, 200) - 100;
    return mk_word(roll, gyro, wheel);
  endfunction

  task automatic offer_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 70);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // drop valid and wait out every pending drive word
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // junk in the upper data bits of the 16-bit registers must be dropped
  task automatic program_regs(input logic [19:0] ag, input logic [15:0] rg, input logic [15:0] sg,
                              input logic [15:0] ig, input logic [15:0] lim);
    write_reg(REG_ANGLE_GAIN, ag);
    write_reg(REG_RATE_GAIN, {4'($urandom), rg});
    write_reg(REG_SPEED_GAIN, {4'($urandom), sg});
    write_reg(REG_INTEGRAL_GAIN, {4'($urandom), ig});
    write_reg(REG_DRIVE_LIMIT, {4'($urandom), lim});
    write_reg(CFG_IDX_W'(REG_DRIVE_LIMIT + $urandom_range(1, 3)), CFG_W'($urandom));
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zone edges, out-of-range roll and field extremes at the reset gains
    offer_word(mk_word(0, 0, 0));
    offer_word(mk_word(-10000, 0, 32767));
    offer_word(mk_word(-9999, 32767, 32767));
    offer_word(mk_word(-7001, -32768, 32767));
    offer_word(mk_word(-7000, 0, 32767));
    offer_word(mk_word(-2000, 100, 32767));
    offer_word(mk_word(-1999, -100, -32768));
    offer_word(mk_word(999, 32767, -32768));
    offer_word(mk_word(1000, -32768, -32768));
    offer_word(mk_word(7000, 0, -32768));
    offer_word(mk_word(7001, 32767, -32768));
    offer_word(mk_word(9999, -32768, 0));
    offer_word(mk_word(10000, 0, 0));
    offer_word(mk_word(17000, 0, 1));
    offer_word(mk_word(17001, 32767, -1));
    offer_word(mk_word(17999, -32768, 32767));
    offer_word(mk_word(18000, 0, 32767));
    offer_word(mk_word(-18000, 0, 32767));
    offer_word(mk_word(-17999, 32767, -32768));
    offer_word(mk_word(-16001, -32768, -32768));
    offer_word(mk_word(-16000, 0, 0));
    offer_word(mk_word(32767, 32767, -32768));
    offer_word(mk_word(-32768, -32768, -32768));
    offer_word(mk_word(-8500, 0, -32768));
    drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: ;
        1: program_regs(20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: program_regs(20'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        3: program_regs(20'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'h0);
        4: program_regs(20'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom));
        5: program_regs(20'($urandom_range(0, 4095)), 16'($urandom_range(0, 255)),
                        16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)), 16'hFFFF);
        6: program_regs(20'hFFFFF, 16'h0, 16'h0, 16'hFFFF, 16'($urandom_range(1, 100)));
        default: program_regs(ANGLE_GAIN_RST, RATE_GAIN_RST, SPEED_GAIN_RST,
                              INTEGRAL_GAIN_RST, DRIVE_LIMIT_RST);
      endcase
      for (int i = 0; i < RAND_PER_PHASE; i++) offer_word(rand_word());
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
